### src/mvt_pkg.sv
package mvt_pkg;

  localparam int unsigned NUM_REGS = 8;

  typedef enum logic [2:0] {
    FN_XFORM   = 3'd0,
    FN_ROT     = 3'd1,
    FN_HXFORM  = 3'd2,
    FN_HROT    = 3'd3,
    FN_IXFORM  = 3'd4,
    FN_IROT    = 3'd5
  } func_t;

endpackage

### src/mvt_div.sv
// Pipelined restoring divider: one quotient bit per stage.
// rin is the starting partial remainder (below den), num the dividend bits shifted
// in MSB first; quo is the QB-bit quotient. Saturation is checked upstream.
module mvt_div #(
  parameter int NW = 64,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rin,
  input  logic [QB-1:0] num,
  input  logic [NW-1:0] den,
  output logic [QB-1:0] quo
);
  logic [NW-1:0] rem [QB+1];
  logic [NW-1:0] dv  [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic [QB-1:0] nm  [QB+1];

  assign rem[0] = rin;
  assign dv[0]  = den;
  assign q[0]   = '0;
  assign nm[0]  = num;

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [NW:0] r2;
    logic [NW:0] df;
    always_comb begin
      r2 = {rem[i], nm[i][QB-1]};
      df = r2 - {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= df[NW] ? r2[NW-1:0] : df[NW-1:0];
        q[i+1]   <= {q[i][QB-2:0], ~df[NW]};
        nm[i+1]  <= {nm[i][QB-2:0], 1'b0};
        dv[i+1]  <= dv[i];
      end
    end
  end
  assign quo = q[QB];
endmodule

### src/matrix_vector_transform_top.sv
// Affine 4x4 vertex transform, row-vector convention, Q(32-FRAC_BITS).FRAC_BITS.
// Throughput: one beat per cycle, sustained; an output stall freezes every stage.
// Pipeline: five stages (operand select, products, sum, round, divider setup),
// 33 one-bit divider stages and the output register.
// The divider runs for every beat so all modes share one latency.
// Reset (rst, synchronous): matrix returns to identity, all valid bits clear.
module matrix_vector_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,  // in_x[31:0], in_y[63:32], in_z[95:64]
  input  logic [2:0]   s_tuser,  // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [1:0]   m_tuser   // div_zero[0], saturated[1]
);
  localparam int QB   = 33;                          // integer, fraction and round bits
  localparam int IB   = 32 - FRAC_BITS;              // integer quotient bits before clipping
  localparam int DEP  = 6 + QB;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] IMAX = 64'sd2147483647;
  localparam logic signed [63:0] IMIN = -64'sd2147483648;

  logic [63:0] regs [8];
  logic [63:0] regs_next [8];

  assign pready = 1'b1;
  always_comb begin
    regs_next = regs;
    if (psel && penable && pwrite)
      regs_next[paddr[5:3]] = pwdata;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'd1 << FRAC_BITS;
      regs[1] <= '0;
      regs[2] <= 64'd1 << (32 + FRAC_BITS);
      regs[3] <= '0;
      regs[4] <= '0;
      regs[5] <= 64'd1 << FRAC_BITS;
      regs[6] <= '0;
      regs[7] <= 64'd1 << (32 + FRAC_BITS);
    end else begin
      regs <= regs_next;
    end
  end
  assign prdata = (paddr[2:0] == 3'd0) ? regs[paddr[5:3]] : '0;

  // entry rc: register {r, c[1]}, high half for odd columns
  function automatic logic signed [31:0] ent(input logic [63:0] r [8], input logic [1:0] rr,
                                              input logic [1:0] cc);
    logic [63:0] w;
    w = r[{rr, cc[1]}];
    return cc[0] ? w[63:32] : w[31:0];
  endfunction

  // pipeline enable: stall everything when output is held
  logic en;
  logic [DEP-1:0] vld;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // stage 1: operand select and inverse difference
  logic [2:0]          f1;
  logic signed [32:0]  a1 [3];
  logic signed [31:0]  b1 [4][3];
  logic signed [31:0]  t1 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= s_tuser;
      for (int j = 0; j < 3; j++) begin
        logic signed [31:0] vj;
        vj = s_tdata[32*j +: 32];
        a1[j] <= (s_tuser == mvt_pkg::FN_IXFORM)
                 ? 33'(vj) - 33'(ent(regs, 2'd3, 2'(j))) : 33'(vj);
      end
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++)
          b1[c][i] <= (s_tuser == mvt_pkg::FN_IXFORM || s_tuser == mvt_pkg::FN_IROT)
                      ? ((c < 3) ? ent(regs, 2'(c), 2'(i)) : 32'sd0)
                      : ent(regs, 2'(i), 2'(c));
        t1[c] <= (s_tuser == mvt_pkg::FN_XFORM || s_tuser == mvt_pkg::FN_HXFORM)
                 ? ent(regs, 2'd3, 2'(c)) : 32'sd0;
      end
    end
  end

  // stage 2: products
  logic [2:0]         f2;
  logic signed [64:0] p2 [4][3];
  logic signed [31:0] t2 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      f2 <= f1;
      t2 <= t1;
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 3; i++)
          p2[c][i] <= a1[i] * 65'(b1[c][i]);
    end
  end

  // stage 3: sum, round half up
  logic [2:0]         f3;
  logic signed [67:0] s3 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      f3 <= f2;
      for (int c = 0; c < 4; c++)
        s3[c] <= 68'(p2[c][0]) + 68'(p2[c][1]) + 68'(p2[c][2])
               + (68'(t2[c]) <<< FRAC_BITS) + 68'(HALF);
    end
  end

  // stage 4: rounded values
  logic [2:0]         f4;
  logic signed [63:0] n4 [4];
  always_ff @(posedge clk) begin
    if (en) begin
      f4 <= f3;
      for (int c = 0; c < 4; c++)
        n4[c] <= 64'(s3[c] >>> FRAC_BITS);
    end
  end

  // stage 5: magnitudes, early clip test and divider operands.
  // The dividend is |n| << (FRAC_BITS+1); its top part seeds the remainder,
  // its low 33 bits are shifted in one per divider stage.
  logic [2:0]         f5;
  logic signed [63:0] n5 [4];
  logic [63:0]        r5 [3];
  logic [QB-1:0]      b5 [3];
  logic [63:0]        w5;
  logic [2:0]         o5;
  always_ff @(posedge clk) begin
    if (en) begin
      logic [63:0] un;
      logic [63:0] uw;
      f5 <= f4;
      n5 <= n4;
      uw = n4[3][63] ? 64'(-n4[3]) : 64'(n4[3]);
      w5 <= uw;
      for (int j = 0; j < 3; j++) begin
        un = n4[j][63] ? 64'(-n4[j]) : 64'(n4[j]);
        r5[j] <= un >> IB;
        b5[j] <= QB'(un << (FRAC_BITS + 1));
        o5[j] <= (un >> IB) >= uw;
      end
    end
  end

  logic [QB-1:0] qd [3];
  for (genvar j = 0; j < 3; j++) begin : g_div
    mvt_div #(.NW(64), .QB(QB)) u_div (.clk(clk), .en(en), .rin(r5[j]), .num(b5[j]),
                                       .den(w5), .quo(qd[j]));
  end

  // delay side data alongside the divider
  logic [2:0]         fd [QB+1];
  logic signed [63:0] nd [QB+1][4];
  logic [2:0]         ovd [QB+1];
  assign fd[0]  = f5;
  assign nd[0]  = n5;
  assign ovd[0] = o5;
  for (genvar k = 0; k < QB; k++) begin : g_dl
    always_ff @(posedge clk)
      if (en) begin
        fd[k+1]  <= fd[k];
        nd[k+1]  <= nd[k];
        ovd[k+1] <= ovd[k];
      end
  end

  // final stage
  logic [95:0]        od;
  logic [1:0]         ou;
  always_ff @(posedge clk) begin
    if (en) begin
      logic sat;
      logic dz;
      logic [95:0] r;
      logic [2:0] ff;
      ff  = fd[QB];
      sat = 1'b0;
      dz  = 1'b0;
      r   = '0;
      if (ff == mvt_pkg::FN_XFORM || ff == mvt_pkg::FN_ROT ||
          ff == mvt_pkg::FN_IXFORM || ff == mvt_pkg::FN_IROT) begin
        for (int j = 0; j < 3; j++) begin
          logic signed [63:0] v;
          v = nd[QB][j];
          if (v > IMAX) begin sat = 1'b1; v = IMAX; end
          else if (v < IMIN) begin sat = 1'b1; v = IMIN; end
          r[32*j +: 32] = v[31:0];
        end
      end else if (ff == mvt_pkg::FN_HXFORM || ff == mvt_pkg::FN_HROT) begin
        if (nd[QB][3] == 64'sd0) begin
          dz = 1'b1;
          sat = 1'b1;
          for (int j = 0; j < 3; j++)
            r[32*j +: 32] = nd[QB][j][63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          for (int j = 0; j < 3; j++) begin
            logic [33:0] q;
            logic neg;
            neg = nd[QB][j][63] ^ nd[QB][3][63];
            q = ({1'b0, qd[j]} + 34'd1) >> 1;
            if (ovd[QB][j]) begin
              // integer part already out of range
              sat = 1'b1; r[32*j +: 32] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (!neg && q > 34'h0_7FFF_FFFF) begin
              sat = 1'b1; r[32*j +: 32] = 32'h7FFF_FFFF;
            end else if (neg && q > 34'h0_8000_0000) begin
              sat = 1'b1; r[32*j +: 32] = 32'h8000_0000;
            end else begin
              r[32*j +: 32] = neg ? 32'(-q) : q[31:0];
            end
          end
        end
      end
      od <= r;
      ou <= {sat, dz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEP-2:0], s_tvalid};
  end

  assign m_tvalid = vld[DEP-1];
  assign m_tdata  = od;
  assign m_tuser  = ou;
endmodule

### src/mvt_checker.sv
module mvt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        s_tready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[1])
    else $error("divide flag without saturation flag");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");
endmodule

bind matrix_vector_transform_top mvt_checker u_chk (.*);
